// ===== src/dssg_pkg.sv =====
// Shared constants, types and the quarter-wave cosine table for the damped sine generator.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package dssg_pkg;

  localparam int PHASE_BITS      = 16;
  localparam int SAMPLE_BITS     = 16;
  localparam int COS_TABLE_DEPTH = 1024;

  localparam int ADDR_BITS = $clog2(COS_TABLE_DEPTH);
  localparam int QTR_BITS  = ADDR_BITS - 2;
  localparam int QUARTER   = COS_TABLE_DEPTH / 4;
  localparam int OUT_SHIFT = 31 - SAMPLE_BITS;

  localparam logic [15:0] ENV_ONE = 16'hFFFF;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_AMP_ONE     = 3'd1;
  localparam logic [2:0] REG_STEP_ONE    = 3'd2;
  localparam logic [2:0] REG_START_ONE   = 3'd3;
  localparam logic [2:0] REG_AMP_TWO     = 3'd4;
  localparam logic [2:0] REG_STEP_TWO    = 3'd5;
  localparam logic [2:0] REG_START_TWO   = 3'd6;
  localparam logic [2:0] REG_DECAY       = 3'd7;

  // Operating modes; the unused code behaves as harmonic
  localparam logic [1:0] MODE_HARMONIC = 2'd0;
  localparam logic [1:0] MODE_DAMPED   = 2'd1;
  localparam logic [1:0] MODE_SUM      = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] amp_one;
    logic [15:0] phase_step_one;
    logic [15:0] phase_start_one;
    logic [14:0] amp_two;
    logic [15:0] phase_step_two;
    logic [15:0] phase_start_two;
    logic [15:0] decay_per_step;
  } cfg_t;

  typedef logic [QUARTER-1:0][14:0] qtab_t;

  // Quarter-wave cosine polynomial, x in Q16 of a quarter turn
  function automatic logic [14:0] quarter_cos(input longint x);
    longint t;
    longint p;
    longint c;
    t = (x * x) >>> 16;
    p = 60;
    p = 1367 - ((t * p) >>> 16);
    p = 16624 - ((t * p) >>> 16);
    p = 80852 - ((t * p) >>> 16);
    c = 65536 - ((t * p) >>> 16);
    if (c < 0) begin
      c = 0;
    end
    c = (c + 1) >>> 1;
    if (c > 32767) begin
      c = 32767;
    end
    return c[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    longint x;
    for (int j = 0; j < QUARTER; j++) begin
      x = (longint'(j) * 4 * 65536) / COS_TABLE_DEPTH;
      tab[j] = quarter_cos(x);
    end
    return tab;
  endfunction

  localparam qtab_t       QTAB   = build_qtab();
  // value at exactly a quarter turn, reached when the mirrored offset is zero
  localparam logic [14:0] QC_END = quarter_cos(longint'(65536));

endpackage

// ===== src/damped_sine_sample_generator_core.sv =====
// Top level of the damped sine generator: sequencer around one shared multiplier.
// Depends on dssg_pkg, dssg_cfg_regs and dssg_cos_lut.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_stall carry one request with in_restart. Each
//   accepted request yields exactly one sample on the output channel.
//   Output channel: out_valid / out_stall carry out_sample (saturated Q1.15)
//   and out_sample_index. The result sits in an output register until taken.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index; write only
//   while no request is in flight.
//   Timing: a request is accepted in the idle cycle, then the shared 17x17
//   multiplier is used four times in turn (damped amplitude, first term,
//   second term, envelope update) followed by a rounding and saturation step.
//   out_valid rises as the sample leaves the rounding step, and in_stall stays
//   high until the block is idle again, so no request overlaps another.
//   If the output register is still full at the final step, the block holds
//   there until the receiver takes the earlier sample.
//   Reset (synchronous, rst_n low) clears the phases, index and pending
//   output, sets the envelope to nearly one and loads the register defaults.

module damped_sine_sample_generator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dssg_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic [15:0]                         out_sample_index,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [15:0]                         cfg_wdata
);

  localparam int PB = dssg_pkg::PHASE_BITS;
  localparam int SB = dssg_pkg::SAMPLE_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_TERM1 = 3'd2;
  localparam logic [2:0] ST_TERM2 = 3'd3;
  localparam logic [2:0] ST_ENV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic signed [32:0] RND_HALF = 33'sd1 <<< (dssg_pkg::OUT_SHIFT - 1);
  localparam logic signed [32:0] SAT_HI   = (33'sd1 <<< (SB - 1)) - 33'sd1;
  localparam logic signed [32:0] SAT_LO   = -(33'sd1 <<< (SB - 1));

  dssg_pkg::cfg_t cfg;

  logic [2:0]           state_r, state_nxt;
  logic [PB-1:0]        phase1_r, phase1_nxt;
  logic [PB-1:0]        phase2_r, phase2_nxt;
  logic [15:0]          env_r, env_nxt;
  logic [15:0]          idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SB-1:0] out_sample_r, out_sample_nxt;
  logic [15:0]          out_index_r, out_index_nxt;
  logic signed [15:0]   cos1_r, cos1_nxt;
  logic signed [15:0]   cos2_r, cos2_nxt;
  logic signed [31:0]   acc_r, acc_nxt;
  logic signed [33:0]   prod_r;

  logic signed [15:0]   cos1_w, cos2_w;
  logic signed [16:0]   mul_a, mul_b;
  logic signed [33:0]   mul_p;
  logic signed [32:0]   rnd;
  logic signed [32:0]   shifted;
  logic signed [SB-1:0] sat;

  dssg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dssg_cos_lut u_cos1 (.phase(phase1_r), .cos_val(cos1_w));
  dssg_cos_lut u_cos2 (.phase(phase2_r), .cos_val(cos2_w));

  // Shared multiplier operand selection
  always_comb begin
    case (state_r)
      ST_LOOK: begin
        mul_a = $signed({2'b00, cfg.amp_one});
        mul_b = $signed({1'b0, env_r});
      end
      ST_TERM1: begin
        if (cfg.mode == dssg_pkg::MODE_DAMPED) begin
          mul_a = $signed({2'b00, prod_r[30:16]});
        end else begin
          mul_a = $signed({2'b00, cfg.amp_one});
        end
        mul_b = 17'(cos1_r);
      end
      ST_TERM2: begin
        mul_a = $signed({2'b00, cfg.amp_two});
        mul_b = 17'(cos2_r);
      end
      default: begin
        mul_a = $signed({1'b0, env_r});
        mul_b = $signed({1'b0, cfg.decay_per_step});
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Round half up, then saturate
  always_comb begin
    rnd     = 33'(acc_r) + RND_HALF;
    shifted = rnd >>> dssg_pkg::OUT_SHIFT;
    if (shifted > SAT_HI) begin
      sat = SB'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat = SB'(SAT_LO);
    end else begin
      sat = shifted[SB-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    phase1_nxt     = phase1_r;
    phase2_nxt     = phase2_r;
    env_nxt        = env_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_index_nxt  = out_index_r;
    cos1_nxt       = cos1_r;
    cos2_nxt       = cos2_r;
    acc_nxt        = acc_r;

    // drop the pending result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            phase1_nxt = PB'(cfg.phase_start_one);
            phase2_nxt = PB'(cfg.phase_start_two);
            env_nxt    = dssg_pkg::ENV_ONE;
            idx_nxt    = '0;
          end
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cos1_nxt  = cos1_w;
        cos2_nxt  = cos2_w;
        state_nxt = ST_TERM1;
      end
      ST_TERM1: begin
        state_nxt = ST_TERM2;
      end
      ST_TERM2: begin
        acc_nxt   = prod_r[31:0];
        state_nxt = ST_ENV;
      end
      ST_ENV: begin
        if (cfg.mode == dssg_pkg::MODE_SUM) begin
          acc_nxt = acc_r + prod_r[31:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = sat;
          out_index_nxt  = idx_r;
          env_nxt        = prod_r[31:16];
          phase1_nxt     = phase1_r + PB'(cfg.phase_step_one);
          phase2_nxt     = phase2_r + PB'(cfg.phase_step_two);
          idx_nxt        = idx_r + 16'd1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase1_r    <= '0;
      phase2_r    <= '0;
      env_r       <= dssg_pkg::ENV_ONE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase1_r    <= phase1_nxt;
      phase2_r    <= phase2_nxt;
      env_r       <= env_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_index_r  <= out_index_nxt;
    cos1_r       <= cos1_nxt;
    cos2_r       <= cos2_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= mul_p;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_sample_index = out_index_r;

endmodule

// ===== src/dssg_cfg_regs.sv =====
// Configuration register bank of the damped sine generator.
// Depends on dssg_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module dssg_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output dssg_pkg::cfg_t    cfg
);

  dssg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode            <= dssg_pkg::MODE_HARMONIC;
      cfg_r.amp_one         <= 15'd16384;
      cfg_r.phase_step_one  <= '0;
      cfg_r.phase_start_one <= '0;
      cfg_r.amp_two         <= '0;
      cfg_r.phase_step_two  <= '0;
      cfg_r.phase_start_two <= '0;
      cfg_r.decay_per_step  <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        dssg_pkg::REG_MODE:      cfg_r.mode            <= cfg_wdata[1:0];
        dssg_pkg::REG_AMP_ONE:   cfg_r.amp_one         <= cfg_wdata[14:0];
        dssg_pkg::REG_STEP_ONE:  cfg_r.phase_step_one  <= cfg_wdata;
        dssg_pkg::REG_START_ONE: cfg_r.phase_start_one <= cfg_wdata;
        dssg_pkg::REG_AMP_TWO:   cfg_r.amp_two         <= cfg_wdata[14:0];
        dssg_pkg::REG_STEP_TWO:  cfg_r.phase_step_two  <= cfg_wdata;
        dssg_pkg::REG_START_TWO: cfg_r.phase_start_two <= cfg_wdata;
        dssg_pkg::REG_DECAY:     cfg_r.decay_per_step  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/dssg_cos_lut.sv =====
// Phase to cosine lookup: quarter-wave table folded over the four quadrants.
// Depends on dssg_pkg for the table, its size and the phase width.
`timescale 1ns / 1ps

module dssg_cos_lut (
  input  logic [dssg_pkg::PHASE_BITS-1:0] phase,
  output logic signed [15:0]              cos_val
);

  logic [dssg_pkg::ADDR_BITS-1:0] idx;
  logic [1:0]                     quad;
  logic [dssg_pkg::QTR_BITS-1:0]  ofs;
  logic [dssg_pkg::QTR_BITS-1:0]  ofs_mir;
  logic [14:0]                    mag_dir;
  logic [14:0]                    mag_mir;

  always_comb begin
    idx     = phase[dssg_pkg::PHASE_BITS-1 -: dssg_pkg::ADDR_BITS];
    quad    = idx[dssg_pkg::ADDR_BITS-1 -: 2];
    ofs     = idx[dssg_pkg::QTR_BITS-1:0];
    // quarter minus offset, wrapping to zero when the offset is zero
    ofs_mir = -ofs;
    mag_dir = dssg_pkg::QTAB[ofs];
    mag_mir = (ofs == '0) ? dssg_pkg::QC_END : dssg_pkg::QTAB[ofs_mir];
    case (quad)
      2'd0:    cos_val = $signed({1'b0, mag_dir});
      2'd1:    cos_val = -$signed({1'b0, mag_mir});
      2'd2:    cos_val = -$signed({1'b0, mag_dir});
      default: cos_val = $signed({1'b0, mag_mir});
    endcase
  end

endmodule

// ===== src/dssg_checker.sv =====
// Port-level checks for the damped sine generator, bound to its top level.
// Depends on dssg_pkg for the sample width and on damped_sine_sample_generator_core.
`timescale 1ns / 1ps

module dssg_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    in_restart,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [dssg_pkg::SAMPLE_BITS-1:0] out_sample,
  input logic [15:0]                             out_sample_index,
  input logic                                    cfg_we,
  input logic [2:0]                              cfg_index,
  input logic [15:0]                             cfg_wdata
);

  logic in_take;

  assign in_take = in_valid && !in_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_sample_index))
    else $error("stalled result changed");

  // the block stays busy through the multiplier passes after a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> !$isunknown(in_restart) ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall
      ##1 in_stall)
    else $error("request accepted during sample computation");

  // reset leaves no pending result and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the output");

  // a fresh result appears only after a request was taken
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_take, 6))
    else $error("result without request");

  // configuration is written only while no request is in flight
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_stall && !out_valid && !$isunknown({cfg_index, cfg_wdata}))
    else $error("configuration overlaps a request");

endmodule

bind damped_sine_sample_generator_core dssg_checker u_dssg_checker (.*);
